// ===== rtl/core/qbps_pkg.sv =====
// Package for the queued beep pattern sequencer.
// Holds item types, register codes and fixed sizes; used by every rtl/core file.
package qbps_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MS    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TONE_DUTY = 1'b1;

   // Register reset values
   localparam logic [15:0] GAP_RESET  = 16'd2500;
   localparam logic [7:0]  DUTY_RESET = 8'h7F;
   localparam logic [7:0]  DUTY_OFF   = 8'h00;

   // Item kinds
   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [7:0]  beep_count;
      logic [15:0] tone_ms;
      logic [15:0] silence_ms;
   } req_item_type;

   typedef struct packed {
      logic [7:0]         buzzer_duty;
      logic               sounding;
      logic               busy_res;
      logic               dropped;
      logic [LEVEL_W-1:0] queue_level;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  beep_count;
      logic [15:0] tone_ms;
      logic [15:0] silence_ms;
   } pattern_type;

   // Sequencer to queue
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   // Queue to sequencer
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      pattern_type        head;
   } fifo_stat_type;

endpackage

// ===== rtl/core/qbps_req_if.sv =====
// Request channel of the beep pattern sequencer: valid, ready and one request item.
// Depends on qbps_pkg for the item type.
interface qbps_req_if
   import qbps_pkg::*;
   ();
   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/qbps_rsp_if.sv =====
// Result channel of the beep pattern sequencer: valid, ready and one result item.
// Depends on qbps_pkg for the item type.
interface qbps_rsp_if
   import qbps_pkg::*;
   ();
   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/qbps_fifo.sv =====
// Pattern queue: flop array with read and write pointers and a fill level.
// Depends on qbps_pkg; driven by qbps_seq through fifo_ctl_type.
module qbps_fifo
   import qbps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  fifo_ctl_type  ctl,
   input  pattern_type   wr_entry,
   output fifo_stat_type stat
);

   pattern_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   // Show the head; an empty queue passes the incoming pattern straight through
   always_comb begin
      stat.level = level_ff;
      if (level_ff == '0) begin
         stat.head = wr_entry;
      end else begin
         stat.head = mem_ff[rd_ptr_ff];
      end
   end

   // Advance pointers and level
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      level_in  = level_ff;
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({ctl.push, ctl.pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store pushed patterns
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// ===== rtl/core/qbps_seq.sv =====
// Beep sequencer: timer, tone/silence phases, configuration registers, queue control.
// Depends on qbps_pkg; drives qbps_fifo and returns the result item for each item.
module qbps_seq
   import qbps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  fire,
   input  req_item_type          item,
   input  fifo_stat_type         stat,
   output fifo_ctl_type          ctl,
   output rsp_item_type          result
);

   logic [15:0] gap_ff, gap_in;
   logic [7:0]  tduty_ff, tduty_in;
   logic        active_ff, active_in;
   logic        tone_on_ff, tone_on_in;
   logic [7:0]  rep_ff, rep_in;
   logic [15:0] cur_tone_ff, cur_tone_in;
   logic [15:0] cur_sil_ff, cur_sil_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        armed_ff, armed_in;
   logic [7:0]  duty_ff, duty_in;

   logic               push_req;
   logic               full;
   logic               lost;
   logic               is_tick;
   logic               expire;
   logic               do_adv;
   logic               run;
   logic [LEVEL_W-1:0] level_after;

   // Hold configuration, take writes
   always_comb begin
      gap_in   = gap_ff;
      tduty_in = tduty_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAP_MS:    gap_in   = csr_wdata;
            CSR_TONE_DUTY: tduty_in = csr_wdata[7:0];
            default:       gap_in   = gap_ff;
         endcase
      end
   end

   // Decode the item
   always_comb begin
      push_req = fire && (item.mode == MODE_ENQUEUE) && (item.beep_count != '0);
      full     = (stat.level >= LEVEL_W'(QUEUE_DEPTH));
      lost     = push_req && full;
      is_tick  = fire && (item.mode == MODE_TICK) && armed_ff;
      expire   = is_tick && (ticks_ff <= 16'd1);
      do_adv   = (push_req && !active_ff) || expire;
      level_after = stat.level + LEVEL_W'(push_req && !full);
   end

   // Count down, then advance the pattern: pop if idle, then step tone/silence/gap
   always_comb begin
      active_in   = active_ff;
      tone_on_in  = tone_on_ff;
      rep_in      = rep_ff;
      cur_tone_in = cur_tone_ff;
      cur_sil_in  = cur_sil_ff;
      ticks_in    = ticks_ff;
      armed_in    = armed_ff;
      duty_in     = duty_ff;
      ctl.push    = push_req && !full;
      ctl.pop     = 1'b0;
      run         = do_adv;

      if (is_tick && !expire) begin
         ticks_in = ticks_ff - 1'b1;
      end
      if (expire) begin
         ticks_in = '0;
         armed_in = 1'b0;
      end

      if (do_adv && !active_ff) begin
         if (level_after == '0) begin
            run = 1'b0;
         end else begin
            ctl.pop     = 1'b1;
            rep_in      = stat.head.beep_count;
            cur_tone_in = stat.head.tone_ms;
            cur_sil_in  = stat.head.silence_ms;
            tone_on_in  = 1'b0;
            active_in   = 1'b1;
         end
      end

      if (run) begin
         armed_in = 1'b1;
         if (!tone_on_in) begin
            if (rep_in == '0) begin
               active_in = 1'b0;
               ticks_in  = gap_ff;
            end else begin
               rep_in     = rep_in - 1'b1;
               duty_in    = tduty_ff;
               tone_on_in = 1'b1;
               ticks_in   = cur_tone_in;
            end
         end else begin
            duty_in    = DUTY_OFF;
            tone_on_in = 1'b0;
            ticks_in   = cur_sil_in;
         end
      end
   end

   // Build the result from the state after this item
   always_comb begin
      result.buzzer_duty = duty_in;
      result.sounding    = tone_on_in;
      result.busy_res    = active_in;
      result.dropped     = lost;
      result.queue_level = level_after - LEVEL_W'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff      <= GAP_RESET;
         tduty_ff    <= DUTY_RESET;
         active_ff   <= 1'b0;
         tone_on_ff  <= 1'b0;
         rep_ff      <= '0;
         cur_tone_ff <= '0;
         cur_sil_ff  <= '0;
         ticks_ff    <= '0;
         armed_ff    <= 1'b0;
         duty_ff     <= DUTY_OFF;
      end else begin
         gap_ff      <= gap_in;
         tduty_ff    <= tduty_in;
         active_ff   <= active_in;
         tone_on_ff  <= tone_on_in;
         rep_ff      <= rep_in;
         cur_tone_ff <= cur_tone_in;
         cur_sil_ff  <= cur_sil_in;
         ticks_ff    <= ticks_in;
         armed_ff    <= armed_in;
         duty_ff     <= duty_in;
      end
   end

endmodule

// ===== rtl/core/queued_beep_pattern_sequencer.sv =====
// Top level of the queued beep pattern sequencer.
// Depends on qbps_pkg, qbps_req_if, qbps_rsp_if, qbps_fifo and qbps_seq.
//
// Usage:
//   req_ch carries items: mode 0 queues a beep pattern (beep_count, tone_ms,
//   silence_ms), mode 1 is a one-millisecond tick. Every item gives exactly
//   one result item on rsp_ch: current buzzer duty, sounding, busy, whether
//   this request was dropped on a full queue, and the queue fill after it.
//   csr_we/csr_index/csr_wdata write gap_ms (index 0) and tone_duty
//   (index 1); write them only while no item is in flight.
// Timing:
//   An item accepted into the input register is processed once the result
//   register can move, and its result is loaded into the result register;
//   throughput is 1 item per cycle while rsp_ch.ready stays high, set by the
//   single pass through the sequencer logic between the input and result
//   registers.
// Reset:
//   Synchronous, active high. Empties the queue, stops any pattern, disarms
//   the timer and loads gap_ms = 2500 and tone_duty = 127.
// Stall:
//   When rsp_ch.ready is low the result register holds; the input register
//   still takes one more item, then req_ch.ready drops until the result moves.
module queued_beep_pattern_sequencer
   import qbps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   qbps_req_if.sink              req_ch,
   qbps_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic          stage_valid_ff, stage_valid_in;
   req_item_type  stage_item_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_item_ff;
   logic          move;
   logic          fire;
   fifo_ctl_type  fifo_ctl;
   fifo_stat_type fifo_stat;
   pattern_type   wr_entry;
   rsp_item_type  result;

   // Handshake control
   always_comb begin
      move           = !out_valid_ff || rsp_ch.ready;
      fire           = stage_valid_ff && move;
      req_ch.ready   = !stage_valid_ff || move;
      stage_valid_in = req_ch.ready ? req_ch.valid : stage_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign wr_entry.beep_count = stage_item_ff.beep_count;
   assign wr_entry.tone_ms    = stage_item_ff.tone_ms;
   assign wr_entry.silence_ms = stage_item_ff.silence_ms;

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Load the input and result registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         stage_item_ff <= req_ch.data;
      end
      if (fire) begin
         out_item_ff <= result;
      end
   end

   qbps_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .ctl      (fifo_ctl),
      .wr_entry (wr_entry),
      .stat     (fifo_stat)
   );

   qbps_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (stage_item_ff),
      .stat      (fifo_stat),
      .ctl       (fifo_ctl),
      .result    (result)
   );

endmodule

// ===== rtl/core/qbps_checker.sv =====
// Port-level checks for the queued beep pattern sequencer, bound to the top level.
// Depends on qbps_pkg for widths and the queue depth.
module qbps_checker
   import qbps_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         buzzer_duty,
   input logic               sounding,
   input logic               busy_res,
   input logic               dropped,
   input logic [LEVEL_W-1:0] queue_level
);

   // A lost request only happens with the queue full; an idle sequencer
   // still pops one pattern right away, leaving one slot free
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dropped |-> queue_level >= LEVEL_W'(QUEUE_DEPTH - 1))
      else $error("dropped item without a full queue");

   // A tone only sounds inside a pattern
   a_tone_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sounding |-> busy_res)
      else $error("tone outside a pattern");

   // Buzzer is silent unless a tone sounds
   a_silent_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !sounding |-> buzzer_duty == '0)
      else $error("nonzero duty while silent");

   // Queue level never exceeds the depth
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> queue_level <= LEVEL_W'(QUEUE_DEPTH))
      else $error("queue level beyond depth");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(queue_level)
         && $stable(buzzer_duty) && $stable(dropped))
      else $error("stalled result changed");

endmodule

bind queued_beep_pattern_sequencer qbps_checker u_qbps_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .buzzer_duty (rsp_ch.data.buzzer_duty),
   .sounding    (rsp_ch.data.sounding),
   .busy_res    (rsp_ch.data.busy_res),
   .dropped     (rsp_ch.data.dropped),
   .queue_level (rsp_ch.data.queue_level)
);
